// ----- rtl/glmd_pkg.sv -----
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared types and constants of the grid local minimum detector.
// ----------------------------------------------------------------------------
package glmd_pkg;

  // Fixed field widths
  localparam int COL_W  = 6;
  localparam int ROW_W  = 16;
  localparam int RISK_W = 32;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word indexes (paddr bits above the byte offset)
  localparam logic [APB_AW-3:0] REG_ROW_WIDTH = 1'b0;

  localparam logic [COL_W-1:0]  ROW_WIDTH_RST = 6'd63;
  localparam logic [ROW_W-1:0]  ROW_MAX       = '1;
  localparam logic [RISK_W-1:0] RISK_MAX      = '1;

  // Classified input item, front to back
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] width;
    logic             frame_end;
  } item_ctl_t;

  // Result item without its height
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              is_low;
    logic [RISK_W-1:0] risk;
    logic              last;
  } res_ctl_t;

  // Which cell an evaluation belongs to
  typedef enum logic [1:0] {
    PH_MAIN,   // cell above the incoming sample
    PH_PREV,   // flush: rest of the previous row
    PH_LAST    // flush: cells of the final row
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_MID,
    ST_RD_SIDE,
    ST_RD_LEFT,
    ST_EVAL
  } state_t;

endpackage

// ----- rtl/glmd_ram.sv -----
// ----------------------------------------------------------------------------
// glmd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module glmd_ram #(
  parameter  int WIDTH = 4,
  parameter  int DEPTH = 63,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/glmd_fifo.sv -----
// ----------------------------------------------------------------------------
// glmd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module glmd_fifo #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = data_r[rptr_r];

  // Advance pointers and count
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/glmd_front.sv -----
// ----------------------------------------------------------------------------
// glmd_front
// Accepts height samples, tracks row and column, and tags each item with
// its position and the effective row width.
// ----------------------------------------------------------------------------
module glmd_front #(
  parameter int MAX_COLS    = 63,
  parameter int HEIGHT_BITS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [HEIGHT_BITS-1:0]   height,
  input  logic                     frame_end,
  output logic                     full,
  input  logic [glmd_pkg::COL_W-1:0] row_width,
  output logic                     q_push,
  output glmd_pkg::item_ctl_t      q_ctl,
  output logic [HEIGHT_BITS-1:0]   q_height,
  input  logic                     q_full
);

  import glmd_pkg::*;

  localparam logic [COL_W-1:0] MAX_W = COL_W'(MAX_COLS);

  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0] width_c, last_col, col_c;
  logic             accept;

  // Clamp the width to 1..MAX_COLS and the column into the row
  always_comb begin
    if (row_width == '0) begin
      width_c = COL_W'(1);
    end else if (row_width > MAX_W) begin
      width_c = MAX_W;
    end else begin
      width_c = row_width;
    end
    last_col = width_c - 1'b1;
    col_c    = (col_cnt_r > last_col) ? last_col : col_cnt_r;
  end

  assign accept   = push & ~q_full;
  assign full     = q_full;
  assign q_push   = accept;
  assign q_height = height;

  always_comb begin
    q_ctl.row       = row_cnt_r;
    q_ctl.col       = col_c;
    q_ctl.width     = width_c;
    q_ctl.frame_end = frame_end;
  end

  // Advance the raster position; frame end starts over
  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (accept) begin
      if (frame_end) begin
        row_cnt_nxt = '0;
        col_cnt_nxt = '0;
      end else if (col_c == last_col) begin
        col_cnt_nxt = '0;
        if (row_cnt_r != ROW_MAX) begin
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end else begin
        col_cnt_nxt = col_c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

endmodule

// ----- rtl/glmd_back.sv -----
// ----------------------------------------------------------------------------
// glmd_back
// Holds the two line buffers and decides cells: one per item, and the
// remaining cells of the last two rows when an item ends the frame.
// ----------------------------------------------------------------------------
module glmd_back #(
  parameter int MAX_COLS    = 63,
  parameter int HEIGHT_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  glmd_pkg::item_ctl_t    q_ctl,
  input  logic [HEIGHT_BITS-1:0] q_height,
  input  logic                   r_full,
  output logic                   r_push,
  output glmd_pkg::res_ctl_t     r_ctl,
  output logic [HEIGHT_BITS-1:0] r_height
);

  import glmd_pkg::*;

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  state_t                 state_r, state_nxt;
  phase_t                 phase_r;
  logic [COL_W-1:0]       k_r;
  item_ctl_t              item_r;
  logic [HEIGHT_BITS-1:0] h_r, mid_r, up_r, right_r, oleft_r;
  logic [RISK_W-1:0]      risk_r;

  logic [HEIGHT_BITS-1:0] n_q, o_q, left_v;
  logic [COL_W-1:0]       k_inc, k_dec;
  logic                   up_ex, left_ex, right_ex, down_ex, left_old;
  logic                   is_low, emit, last, item_done, stall, go, load;
  logic [RISK_W:0]        risk_sum;
  logic [RISK_W-1:0]      risk_upd;
  logic                   n_re, o_re, buf_we;
  logic [COL_W-1:0]       n_addr, o_addr;

  // Line buffers: newer holds the latest row, older the one before
  glmd_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_COLS)) u_newer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (k_r[AW-1:0]),
    .wdata (h_r),
    .re    (n_re),
    .raddr (n_addr[AW-1:0]),
    .rdata (n_q)
  );

  glmd_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_COLS)) u_older (
    .clk   (clk),
    .we    (buf_we),
    .waddr (k_r[AW-1:0]),
    .wdata (mid_r),
    .re    (o_re),
    .raddr (o_addr[AW-1:0]),
    .rdata (o_q)
  );

  // Neighbor presence for the cell under evaluation
  always_comb begin
    k_inc    = k_r + 1'b1;
    k_dec    = k_r - 1'b1;
    up_ex    = 1'b0;
    left_ex  = 1'b0;
    right_ex = 1'b0;
    down_ex  = 1'b0;
    left_old = 1'b0;
    emit     = 1'b1;
    last     = 1'b0;
    unique case (phase_r)
      PH_MAIN: begin
        up_ex    = (item_r.row >= ROW_W'(2));
        left_ex  = (k_r != '0);
        right_ex = (k_inc < item_r.width);
        down_ex  = 1'b1;
        left_old = 1'b1;
        emit     = (item_r.row != '0);
      end
      PH_PREV: begin
        up_ex    = (item_r.row >= ROW_W'(2));
        left_ex  = 1'b1;
        right_ex = (k_inc < item_r.width);
        left_old = (k_dec == item_r.col);
      end
      PH_LAST: begin
        up_ex    = (item_r.row != '0);
        left_ex  = (k_r != '0);
        right_ex = (k_r < item_r.col);
        last     = (k_r == item_r.col);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Low-point test and saturating risk update
  always_comb begin
    left_v   = left_old ? oleft_r : n_q;
    is_low   = (!up_ex    || (mid_r < up_r))    &&
               (!left_ex  || (mid_r < left_v))  &&
               (!right_ex || (mid_r < right_r)) &&
               (!down_ex  || (mid_r < h_r));
    risk_sum = {1'b0, risk_r} + (RISK_W+1)'(mid_r) + (RISK_W+1)'(1);
    if (!is_low) begin
      risk_upd = risk_r;
    end else if (risk_sum[RISK_W]) begin
      risk_upd = RISK_MAX;
    end else begin
      risk_upd = risk_sum[RISK_W-1:0];
    end
  end

  assign item_done = ((phase_r == PH_MAIN) && !item_r.frame_end) ||
                     ((phase_r == PH_LAST) && last);
  assign stall     = emit & r_full;
  assign go        = (state_r == ST_EVAL) & ~stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (!q_empty) state_nxt = ST_RD_MID;
      ST_RD_MID:  state_nxt = ST_RD_SIDE;
      ST_RD_SIDE: state_nxt = ST_RD_LEFT;
      ST_RD_LEFT: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (!stall) begin
          if (item_done && q_empty) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD_MID;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: buffer reads and writes, queue handshakes
  always_comb begin
    n_re   = 1'b0;
    o_re   = 1'b0;
    n_addr = k_r;
    o_addr = k_r;
    buf_we = 1'b0;
    load   = 1'b0;
    r_push = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        load = ~q_empty;
      end
      ST_RD_MID: begin
        n_re = 1'b1;
        o_re = 1'b1;
      end
      ST_RD_SIDE: begin
        n_re   = 1'b1;
        o_re   = 1'b1;
        n_addr = right_ex ? k_inc : k_r;
        o_addr = (k_r != '0) ? k_dec : k_r;
      end
      ST_RD_LEFT: begin
        n_re   = 1'b1;
        n_addr = (k_r != '0) ? k_dec : k_r;
      end
      ST_EVAL: begin
        r_push = go & emit;
        buf_we = go & (phase_r == PH_MAIN);
        load   = go & item_done & ~q_empty;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  always_comb begin
    r_ctl.row    = (phase_r == PH_LAST) ? item_r.row : item_r.row - 1'b1;
    r_ctl.col    = k_r;
    r_ctl.is_low = is_low;
    r_ctl.risk   = risk_upd;
    r_ctl.last   = last;
  end
  assign r_height = mid_r;

  // Sequencer control: state, phase, column, risk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MAIN;
      k_r     <= '0;
      risk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // Drop the risk sum once the frame's final cell is out, else accumulate
      if (go && (phase_r == PH_LAST) && last) begin
        risk_r <= '0;
      end else if (go && emit) begin
        risk_r <= risk_upd;
      end
      if (load) begin
        phase_r <= PH_MAIN;
        k_r     <= q_ctl.col;
      end else if (go && !item_done) begin
        unique case (phase_r)
          PH_MAIN: begin
            if ((item_r.row != '0) && (k_inc < item_r.width)) begin
              phase_r <= PH_PREV;
              k_r     <= k_inc;
            end else begin
              phase_r <= PH_LAST;
              k_r     <= '0;
            end
          end
          PH_PREV: begin
            if (k_inc < item_r.width) begin
              k_r <= k_inc;
            end else begin
              phase_r <= PH_LAST;
              k_r     <= '0;
            end
          end
          PH_LAST: k_r <= k_inc;
          default: phase_r <= PH_MAIN;
        endcase
      end
    end
  end

  // Capture the item and the neighbor heights as they come back
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_ctl;
      h_r    <= q_height;
    end
    if (state_r == ST_RD_SIDE) begin
      mid_r <= n_q;
      up_r  <= o_q;
    end
    if (state_r == ST_RD_LEFT) begin
      right_r <= n_q;
      oleft_r <= o_q;
    end
  end

endmodule

// ----- rtl/grid_local_minimum_detector.sv -----
// ----------------------------------------------------------------------------
// grid_local_minimum_detector: four-neighbor low points of a streamed grid
// Each item passes three line buffer read slots and an evaluate step in the
// decide unit, held there while the result queue is full; a frame-end item
// repeats them per flushed cell. Sync reset clears counts.
// ----------------------------------------------------------------------------
module grid_local_minimum_detector #(
  parameter int MAX_COLS    = 63,
  parameter int HEIGHT_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input samples
  input  logic                          push,
  output logic                          full,
  input  logic [HEIGHT_BITS-1:0]        in_height,
  input  logic                          in_frame_end,
  // results
  output logic                          empty,
  input  logic                          pop,
  output logic [glmd_pkg::ROW_W-1:0]    out_cell_row,
  output logic [glmd_pkg::COL_W-1:0]    out_cell_col,
  output logic [HEIGHT_BITS-1:0]        out_cell_height,
  output logic                          out_is_low,
  output logic [glmd_pkg::RISK_W-1:0]   out_risk_total,
  output logic                          out_last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glmd_pkg::APB_AW-1:0]   paddr,
  input  logic [glmd_pkg::APB_DW-1:0]   pwdata,
  output logic [glmd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  import glmd_pkg::*;

  localparam int ITEM_W = $bits(item_ctl_t) + HEIGHT_BITS;
  localparam int RES_W  = $bits(res_ctl_t) + HEIGHT_BITS;

  logic [COL_W-1:0]       row_width_r;
  logic                   reg_sel;

  logic                   iq_push, iq_full, iq_pop, iq_empty;
  item_ctl_t              iq_ctl_in, iq_ctl_out;
  logic [HEIGHT_BITS-1:0] iq_h_in, iq_h_out;

  logic                   rq_push, rq_full;
  res_ctl_t               rq_ctl_in, rq_ctl_out;
  logic [HEIGHT_BITS-1:0] rq_h_in, rq_h_out;

  // Configuration register
  assign reg_sel = (paddr[APB_AW-1:2] == REG_ROW_WIDTH);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DW'(row_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      row_width_r <= pwdata[COL_W-1:0];
    end
  end

  // Front: accept and classify
  glmd_front #(.MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .height    (in_height),
    .frame_end (in_frame_end),
    .full      (full),
    .row_width (row_width_r),
    .q_push    (iq_push),
    .q_ctl     (iq_ctl_in),
    .q_height  (iq_h_in),
    .q_full    (iq_full)
  );

  // Item queue between front and back
  glmd_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (iq_push),
    .wdata ({iq_ctl_in, iq_h_in}),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata ({iq_ctl_out, iq_h_out}),
    .empty (iq_empty)
  );

  // Back: line buffers and cell decisions
  glmd_back #(.MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (iq_empty),
    .q_pop    (iq_pop),
    .q_ctl    (iq_ctl_out),
    .q_height (iq_h_out),
    .r_full   (rq_full),
    .r_push   (rq_push),
    .r_ctl    (rq_ctl_in),
    .r_height (rq_h_in)
  );

  // Result queue toward the consumer
  glmd_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata ({rq_ctl_in, rq_h_in}),
    .full  (rq_full),
    .pop   (pop),
    .rdata ({rq_ctl_out, rq_h_out}),
    .empty (empty)
  );

  assign out_cell_row    = rq_ctl_out.row;
  assign out_cell_col    = rq_ctl_out.col;
  assign out_cell_height = rq_h_out;
  assign out_is_low      = rq_ctl_out.is_low;
  assign out_risk_total  = rq_ctl_out.risk;
  assign out_last        = rq_ctl_out.last;

endmodule
